@@ hw/rtl/lr_pkg.sv @@
// Shared constants, types and helpers of the line rasterizer.
package lr_pkg;

  // Default coordinate width: a 64 by 64 pixel tile.
  localparam int COORD_BITS_DEF = 6;

  // Entries in the line queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  // Fill status of the line queue.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Width of one packed line descriptor:
  // major start, minor start, major end (cb each), four flags,
  // doubled major and minor spans (cb+1 each), error term (cb+3).
  function automatic int desc_width(input int cb);
    return 6 * cb + 9;
  endfunction

endpackage

@@ hw/rtl/line_rasterizer_unit.sv @@
// Top level of the Bresenham line rasterizer: front, line queue and back.
//
// Usage:
//   Input channel (in_valid / in_stall): one word carries the start and end
//   points of a line inside a 2^COORD_BITS square tile. A word is taken at a
//   rising edge with in_valid high and in_stall low.
//   Output channel (out_valid / out_stall): one word per pixel, start pixel
//   first, endpoint last with out_last_pixel set. A line yields
//   max(|dx|,|dy|)+1 words, at most 2^COORD_BITS.
//   Path: the endpoints of a line pass through the front's hold register
//   and a queue slot; its first pixel enters the output register from the
//   queue head when the back is idle.
//   Throughput: one pixel per cycle while out_stall is low; the back stepper,
//   which advances the error term once per unstalled cycle, sets this rate.
//   The front holds one classified line and the queue holds QUEUE_DEPTH more,
//   so new lines are taken while the back still draws an earlier one.
//   Reset (rst_n low, synchronous) drops every queued line and clears both
//   valids; in_stall is low after reset.
//   When the receiver stalls, the output word holds and the back pauses;
//   once the queue and front fill up, in_stall rises.
module line_rasterizer_unit #(
  parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [COORD_BITS-1:0] in_start_x,
  input  logic [COORD_BITS-1:0] in_start_y,
  input  logic [COORD_BITS-1:0] in_end_x,
  input  logic [COORD_BITS-1:0] in_end_y,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [COORD_BITS-1:0] out_pixel_x,
  output logic [COORD_BITS-1:0] out_pixel_y,
  output logic                  out_last_pixel
);

  // Packed descriptor width follows the coordinate width.
  localparam int DESC_W = lr_pkg::desc_width(COORD_BITS);

  logic              push;
  logic [DESC_W-1:0] push_data;
  logic              pop;
  logic [DESC_W-1:0] pop_data;
  lr_pkg::q_stat_t   q_stat;

  // Classify: major axis, step directions, doubled spans, initial error.
  lr_front #(
    .COORD_BITS (COORD_BITS),
    .DESC_W     (DESC_W)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_start_x (in_start_x),
    .in_start_y (in_start_y),
    .in_end_x   (in_end_x),
    .in_end_y   (in_end_y),
    .push       (push),
    .push_data  (push_data),
    .q_stat     (q_stat)
  );

  // Decouple classification from drawing.
  lr_queue #(
    .WIDTH (DESC_W),
    .DEPTH (lr_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_stat    (q_stat)
  );

  // Draw: one pixel per cycle into the output register while the receiver does not stall.
  lr_back #(
    .COORD_BITS (COORD_BITS),
    .DESC_W     (DESC_W)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .pop_data       (pop_data),
    .q_stat         (q_stat),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pixel_x    (out_pixel_x),
    .out_pixel_y    (out_pixel_y),
    .out_last_pixel (out_last_pixel)
  );

endmodule

@@ hw/rtl/lr_front.sv @@
// Front part: accepts endpoints and classifies them into a line descriptor.
module lr_front #(
  parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF,
  parameter int DESC_W     = lr_pkg::desc_width(COORD_BITS)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [COORD_BITS-1:0] in_start_x,
  input  logic [COORD_BITS-1:0] in_start_y,
  input  logic [COORD_BITS-1:0] in_end_x,
  input  logic [COORD_BITS-1:0] in_end_y,
  output logic                  push,
  output logic [DESC_W-1:0]     push_data,
  input  lr_pkg::q_stat_t       q_stat
);

  localparam int C = COORD_BITS;

  logic              hold_valid_r;
  logic              hold_valid_nxt;
  logic [DESC_W-1:0] desc_r;
  logic [DESC_W-1:0] desc_nxt;

  logic [C:0]   dx;
  logic [C:0]   dy;
  logic [C:0]   dx_abs;
  logic [C:0]   dy_abs;
  logic         x_major;
  logic [C-1:0] amaj;
  logic [C-1:0] amin;
  logic [C:0]   ddmaj;
  logic [C:0]   ddmin;
  logic [C+2:0] err0;
  logic         maj_neg;
  logic         min_neg;
  logic         min_zero;
  logic         accept;

  assign dx     = {1'b0, in_end_x} - {1'b0, in_start_x};
  assign dy     = {1'b0, in_end_y} - {1'b0, in_start_y};
  assign dx_abs = dx[C] ? (~dx + {{C{1'b0}}, 1'b1}) : dx;
  assign dy_abs = dy[C] ? (~dy + {{C{1'b0}}, 1'b1}) : dy;

  // Equal spans count as x-major.
  assign x_major  = dx_abs[C-1:0] >= dy_abs[C-1:0];
  assign amaj     = x_major ? dx_abs[C-1:0] : dy_abs[C-1:0];
  assign amin     = x_major ? dy_abs[C-1:0] : dx_abs[C-1:0];
  assign maj_neg  = x_major ? dx[C] : dy[C];
  assign min_neg  = x_major ? dy[C] : dx[C];
  assign min_zero = (amin == '0);
  assign ddmaj    = {amaj, 1'b0};
  assign ddmin    = {amin, 1'b0};
  assign err0     = {2'b00, ddmin} - {3'b000, amaj};

  assign in_stall = hold_valid_r && q_stat.full;
  assign accept   = in_valid && !in_stall;
  assign push     = hold_valid_r && !q_stat.full;
  assign push_data = desc_r;

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    desc_nxt       = desc_r;
    if (push) begin
      hold_valid_nxt = 1'b0;
    end
    if (accept) begin
      hold_valid_nxt = 1'b1;
      desc_nxt = {
        (x_major ? in_start_x : in_start_y),
        (x_major ? in_start_y : in_start_x),
        (x_major ? in_end_x   : in_end_y),
        x_major, maj_neg, min_zero, min_neg,
        ddmaj, ddmin, err0
      };
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    desc_r <= desc_nxt;
  end

endmodule

@@ hw/rtl/lr_queue.sv @@
// Short register queue of line descriptors between front and back.
module lr_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = lr_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output lr_pkg::q_stat_t  q_stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [PTR_W-1:0] PTR_ONE  = PTR_W'(1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W-1:0] rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;

  assign q_stat.full  = (cnt_r == CNT_FULL);
  assign q_stat.empty = (cnt_r == '0);
  assign pop_data     = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_ONE;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_ONE;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_ONE;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ hw/rtl/lr_back.sv @@
// Back part: steps the Bresenham error term and emits one pixel per cycle unless the output stalls.
module lr_back #(
  parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF,
  parameter int DESC_W     = lr_pkg::desc_width(COORD_BITS)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [DESC_W-1:0]     pop_data,
  input  lr_pkg::q_stat_t       q_stat,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [COORD_BITS-1:0] out_pixel_x,
  output logic [COORD_BITS-1:0] out_pixel_y,
  output logic                  out_last_pixel
);

  localparam int C = COORD_BITS;
  localparam logic [C-1:0] ONE = C'(1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } bk_state_t;

  bk_state_t state_r;
  bk_state_t state_nxt;

  // Unpacked descriptor at the queue head.
  logic [C-1:0] d_maj;
  logic [C-1:0] d_min;
  logic [C-1:0] d_maj_end;
  logic         d_xmaj;
  logic         d_maj_neg;
  logic         d_min_zero;
  logic         d_min_neg;
  logic [C:0]   d_ddmaj;
  logic [C:0]   d_ddmin;
  logic [C+2:0] d_err;

  assign {d_maj, d_min, d_maj_end, d_xmaj, d_maj_neg, d_min_zero, d_min_neg,
          d_ddmaj, d_ddmin, d_err} = pop_data;

  logic [C-1:0] maj_r,     maj_nxt;
  logic [C-1:0] min_r,     min_nxt;
  logic [C-1:0] maj_end_r, maj_end_nxt;
  logic         xmaj_r,    xmaj_nxt;
  logic         maj_neg_r, maj_neg_nxt;
  logic         min_zero_r, min_zero_nxt;
  logic         min_neg_r, min_neg_nxt;
  logic [C:0]   ddmaj_r,   ddmaj_nxt;
  logic [C:0]   ddmin_r,   ddmin_nxt;
  logic [C+2:0] err_r,     err_nxt;

  logic         out_valid_r, out_valid_nxt;
  logic [C-1:0] out_x_r,     out_x_nxt;
  logic [C-1:0] out_y_r,     out_y_nxt;
  logic         out_last_r,  out_last_nxt;

  logic         slot_free;
  logic         step_min;
  logic [C+2:0] err_sub;
  logic [C+2:0] err_step;
  logic [C-1:0] maj_step;
  logic [C-1:0] min_step;
  logic         step_last;
  logic         load_last;

  assign slot_free = !out_valid_r || !out_stall;
  assign pop = (state_r == ST_IDLE) && !q_stat.empty && slot_free;

  // Step the minor axis on a positive error, or on a tie with a forward major step.
  assign step_min  = (!err_r[C+2] && (err_r != '0)) || ((err_r == '0) && !maj_neg_r);
  assign err_sub   = step_min ? (err_r - {2'b00, ddmaj_r}) : err_r;
  assign err_step  = err_sub + {2'b00, ddmin_r};
  assign maj_step  = maj_neg_r ? (maj_r - ONE) : (maj_r + ONE);
  assign min_step  = (!step_min || min_zero_r) ? min_r :
                     (min_neg_r ? (min_r - ONE) : (min_r + ONE));
  assign step_last = (maj_step == maj_end_r);
  assign load_last = (d_maj == d_maj_end);

  always_comb begin
    state_nxt     = state_r;
    maj_nxt       = maj_r;
    min_nxt       = min_r;
    maj_end_nxt   = maj_end_r;
    xmaj_nxt      = xmaj_r;
    maj_neg_nxt   = maj_neg_r;
    min_zero_nxt  = min_zero_r;
    min_neg_nxt   = min_neg_r;
    ddmaj_nxt     = ddmaj_r;
    ddmin_nxt     = ddmin_r;
    err_nxt       = err_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_last_nxt  = out_last_r;
    case (state_r)
      ST_IDLE: begin
        if (pop) begin
          maj_nxt       = d_maj;
          min_nxt       = d_min;
          maj_end_nxt   = d_maj_end;
          xmaj_nxt      = d_xmaj;
          maj_neg_nxt   = d_maj_neg;
          min_zero_nxt  = d_min_zero;
          min_neg_nxt   = d_min_neg;
          ddmaj_nxt     = d_ddmaj;
          ddmin_nxt     = d_ddmin;
          err_nxt       = d_err;
          out_valid_nxt = 1'b1;
          out_x_nxt     = d_xmaj ? d_maj : d_min;
          out_y_nxt     = d_xmaj ? d_min : d_maj;
          out_last_nxt  = load_last;
          state_nxt     = load_last ? ST_IDLE : ST_RUN;
        end
      end
      ST_RUN: begin
        if (slot_free) begin
          maj_nxt       = maj_step;
          min_nxt       = min_step;
          err_nxt       = err_step;
          out_valid_nxt = 1'b1;
          out_x_nxt     = xmaj_r ? maj_step : min_step;
          out_y_nxt     = xmaj_r ? min_step : maj_step;
          out_last_nxt  = step_last;
          state_nxt     = step_last ? ST_IDLE : ST_RUN;
        end
      end
      default: begin
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    maj_r      <= maj_nxt;
    min_r      <= min_nxt;
    maj_end_r  <= maj_end_nxt;
    xmaj_r     <= xmaj_nxt;
    maj_neg_r  <= maj_neg_nxt;
    min_zero_r <= min_zero_nxt;
    min_neg_r  <= min_neg_nxt;
    ddmaj_r    <= ddmaj_nxt;
    ddmin_r    <= ddmin_nxt;
    err_r      <= err_nxt;
    out_x_r    <= out_x_nxt;
    out_y_r    <= out_y_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_pixel_x    = out_x_r;
  assign out_pixel_y    = out_y_r;
  assign out_last_pixel = out_last_r;

endmodule

@@ hw/rtl/lr_checker.sv @@
// Port-level checker of the line rasterizer, bound to the top level.
module lr_checker #(
  parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [COORD_BITS-1:0] out_pixel_x,
  input logic [COORD_BITS-1:0] out_pixel_y,
  input logic                  out_last_pixel
);

  localparam logic [COORD_BITS-1:0] ONE = COORD_BITS'(1);

  logic                  out_fire;
  logic                  mid_line_r;
  logic [COORD_BITS-1:0] prev_x_r;
  logic [COORD_BITS-1:0] prev_y_r;
  logic                  near_x;
  logic                  near_y;
  logic                  same_xy;

  assign out_fire = out_valid && !out_stall;
  assign near_x   = (out_pixel_x == prev_x_r) || (out_pixel_x == prev_x_r + ONE) ||
                    (prev_x_r == out_pixel_x + ONE);
  assign near_y   = (out_pixel_y == prev_y_r) || (out_pixel_y == prev_y_r + ONE) ||
                    (prev_y_r == out_pixel_y + ONE);
  assign same_xy  = (out_pixel_x == prev_x_r) && (out_pixel_y == prev_y_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_line_r <= 1'b0;
    end else if (out_fire) begin
      mid_line_r <= !out_last_pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (out_fire) begin
      prev_x_r <= out_pixel_x;
      prev_y_r <= out_pixel_y;
    end
  end

  // A stalled output word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pixel_x) &&
      $stable(out_pixel_y) && $stable(out_last_pixel))
    else $error("stalled output word changed");

  // Reset empties the block.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

  // Within a line, each pixel is a neighbor of the one before it.
  a_adjacent: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && mid_line_r |-> near_x && near_y && !same_xy)
    else $error("consecutive line pixels not adjacent");

  // The input is not held off when nothing is waiting to be classified.
  a_no_spurious_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(in_valid) && !$past(in_stall) && $past(rst_n) |-> !in_stall)
    else $error("input stalled with no line pending");

endmodule

bind line_rasterizer_unit lr_checker #(
  .COORD_BITS (COORD_BITS)
) u_lr_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_pixel_x    (out_pixel_x),
  .out_pixel_y    (out_pixel_y),
  .out_last_pixel (out_last_pixel)
);
